// ----- rtl/core/lfr_pkg.sv -----
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants of the LRU frame replacer.
// ----------------------------------------------------------------------------
package lfr_pkg;

	localparam int FRAMES_DEF = 64;
	localparam int FRAME_W    = 6;
	localparam int COUNT_W    = 7;

	typedef enum logic [1:0] {
		OP_VICTIM = 2'd0,
		OP_PIN    = 2'd1,
		OP_UNPIN  = 2'd2
	} op_t;

	// list update request for one step
	typedef struct packed {
		logic push;    // insert key at head
		logic remove;  // drop matching entry, close gap
		logic pop;     // drop tail entry
	} list_ctl_t;

	// lookup results on the current list
	typedef struct packed {
		logic               hit;   // key is in the list
		logic [FRAME_W-1:0] tail;  // oldest entry (valid when list not empty)
	} list_stat_t;

endpackage

// ----- rtl/core/lru_frame_replacer.sv -----
// ----------------------------------------------------------------------------
// lru_frame_replacer
// Least-recently-unpinned frame replacer: victim, pin and unpin commands.
// ----------------------------------------------------------------------------
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  command   | start / busy (0)      | operation, frame_number
//  result    | done (1-cycle strobe) | found, victim_frame, evictable_count
//
//  One command per cycle, every cycle. busy is held low.
//  A command passes the input register, then the list update and result
//  register, before its result is shown and transferred.
//  The list update is a single pass over the cell row: head insert shifts
//  every cell down, a pin compacts the cells at and after the matching one.
//  Reset clears the entry count; list cells are not reset (cells at or above
//  the count are never looked at).
//  The receiver cannot stall: each result transfer lasts exactly one cycle.
//
module lru_frame_replacer #(
	parameter int FRAMES = lfr_pkg::FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [lfr_pkg::FRAME_W-1:0] frame_number,
	output logic                        done,
	output logic                        found,
	output logic [lfr_pkg::FRAME_W-1:0] victim_frame,
	output logic [lfr_pkg::COUNT_W-1:0] evictable_count
);
	import lfr_pkg::*;

	localparam int CW = $clog2(FRAMES + 1);

	// stage 1: registered command
	logic               valid_s1;
	op_t                op_s1;
	logic [FRAME_W-1:0] frame_s1;

	// list interface
	list_ctl_t          ctl;
	list_stat_t         stat;
	logic [CW-1:0]      count;
	logic [CW-1:0]      count_next;

	logic               in_range;
	logic               not_full;

	// result register
	logic               done_q;
	logic               found_q;
	logic [FRAME_W-1:0] victim_q;
	logic [COUNT_W-1:0] count_q;

	// every cycle can take a command
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1    <= op_t'(operation);
			frame_s1 <= frame_number;
		end
	end

	// frames at or above FRAMES are ignored by pin and unpin
	assign in_range = 32'(frame_s1) < FRAMES;
	assign not_full = 32'(count) < FRAMES;

	// decode the command against the current list contents
	always_comb begin
		ctl = '0;
		if (valid_s1) begin
			unique case (op_s1)
				OP_VICTIM: ctl.pop    = count != '0;
				OP_PIN:    ctl.remove = in_range && stat.hit;
				OP_UNPIN:  ctl.push   = in_range && !stat.hit && not_full;
				default:   ctl = '0;  // unused code: no change
			endcase
		end
	end

	lfr_order_list #(
		.FRAMES (FRAMES),
		.CW     (CW)
	) u_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        (frame_s1),
		.ctl        (ctl),
		.stat       (stat),
		.count      (count),
		.count_next (count_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// result payload: count after the step, tail only on a real eviction
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			found_q  <= ctl.pop;
			victim_q <= ctl.pop ? stat.tail : '0;
			count_q  <= COUNT_W'(count_next);
		end
	end

	assign done            = done_q;
	assign found           = found_q;
	assign victim_frame    = victim_q;
	assign evictable_count = count_q;

endmodule

// ----- rtl/core/lfr_order_list.sv -----
// ----------------------------------------------------------------------------
// lfr_order_list
// Shifting list of frame numbers, newest at cell 0, with a per-cell match.
// ----------------------------------------------------------------------------
module lfr_order_list #(
	parameter int FRAMES = lfr_pkg::FRAMES_DEF,
	parameter int CW     = $clog2(FRAMES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lfr_pkg::FRAME_W-1:0] key,
	input  lfr_pkg::list_ctl_t         ctl,
	output lfr_pkg::list_stat_t        stat,
	output logic [CW-1:0]              count,
	output logic [CW-1:0]              count_next
);
	import lfr_pkg::*;

	localparam int IW = $clog2(FRAMES);

	logic [FRAME_W-1:0] entry_q [FRAMES];
	logic [CW-1:0]      count_q;
	logic [FRAMES-1:0]  valid;
	logic [FRAMES-1:0]  match;
	logic [FRAMES-1:0]  shift_up;
	logic [IW-1:0]      pos;
	logic [CW-1:0]      tail_cnt;

	// Frames in the list are distinct, so match is one-hot; encode its position.
	always_comb begin
		pos = '0;
		for (int j = 0; j < FRAMES; j++) begin
			if (match[j]) begin
				pos = pos | IW'(j);
			end
		end
	end

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		logic [FRAME_W-1:0] from_prev;
		logic [FRAME_W-1:0] from_next;

		if (g == 0) begin : g_head
			assign from_prev = key;
		end else begin : g_mid
			assign from_prev = entry_q[g-1];
		end
		if (g == FRAMES - 1) begin : g_last
			assign from_next = entry_q[g];
		end else begin : g_inner
			assign from_next = entry_q[g+1];
		end

		assign valid[g]    = CW'(g) < count_q;
		assign match[g]    = valid[g] && (entry_q[g] == key);
		assign shift_up[g] = IW'(g) >= pos;

		always_ff @(posedge clk) begin
			if (ctl.push) begin
				entry_q[g] <= from_prev;
			end else if (ctl.remove && shift_up[g]) begin
				entry_q[g] <= from_next;
			end
		end
	end

	assign tail_cnt  = count_q - CW'(1);
	assign stat.hit  = |match;
	assign stat.tail = entry_q[tail_cnt[IW-1:0]];

	always_comb begin
		count_next = count_q;
		if (ctl.push) begin
			count_next = count_q + CW'(1);
		end else if (ctl.remove || ctl.pop) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign count = count_q;

endmodule

// ----- rtl/core/lfr_checker.sv -----
// ----------------------------------------------------------------------------
// lfr_checker
// Port-level checks of the LRU frame replacer, bound to the top level.
// ----------------------------------------------------------------------------
module lfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [1:0]                  operation,
	input logic [lfr_pkg::FRAME_W-1:0] frame_number,
	input logic                        done,
	input logic                        found,
	input logic [lfr_pkg::FRAME_W-1:0] victim_frame,
	input logic [lfr_pkg::COUNT_W-1:0] evictable_count
);
	import lfr_pkg::*;

	// every command gives exactly one result, after the input and result registers
	a_cmd_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("command without result");

	a_result_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without command");

	// no eviction reported means no frame number
	a_no_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (victim_frame == '0))
		else $error("victim frame set without eviction");

	// an eviction right after another result lowers the count by one
	a_evict_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found && $past(done)) |->
			(evictable_count + COUNT_W'(1) == $past(evictable_count)))
		else $error("eviction count step wrong");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (evictable_count <= COUNT_W'(64)))
		else $error("count out of range");

endmodule

bind lru_frame_replacer lfr_checker u_lfr_checker (.*);
